FILE: hdl/tsg_pkg.sv
package tsg_pkg;

  localparam int unsigned MtuW = 14;
  localparam logic [MtuW-1:0] MtuReset = 14'd1500;

  // segment count limit and width of the segment index
  localparam logic [5:0] MaxSegs = 6'd61;
  localparam int unsigned SegIdxW = 6;

  typedef enum logic [1:0] {
    StWhole = 2'd0,
    StSeg   = 2'd1,
    StDrop  = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic emit_whole;
    logic emit_drop;
    logic emit_seg;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass;
    logic drop;
    logic last;
  } stat_t;

endpackage

FILE: hdl/tsg_dp.sv
module tsg_dp import tsg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output stat_t           stat_o,
  input  logic            cfg_we_i,
  input  logic [MtuW-1:0] cfg_mtu_i,
  input  logic [5:0]      ip_header_len_i,
  input  logic [5:0]      tcp_header_len_i,
  input  logic [15:0]     total_len_i,
  input  logic [15:0]     received_len_i,
  input  logic [31:0]     seq_number_i,
  input  logic [15:0]     ip_ident_i,
  output logic [1:0]      status_o,
  output logic [31:0]     seg_seq_o,
  output logic [15:0]     seg_total_len_o,
  output logic [15:0]     seg_ident_o,
  output logic [15:0]     payload_offset_o,
  output logic [15:0]     payload_len_o,
  output logic            last_segment_o
);

  logic [MtuW-1:0]    mtu_q;
  logic [6:0]         head_q;
  logic [15:0]        tot_q, rcv_q, ident_q;
  logic [31:0]        seq_q;
  logic [MtuW-1:0]    maxp_q;
  logic [15:0]        rem_q, off_q;
  logic [SegIdxW-1:0] idx_q;
  logic               pass_q, bad_q;

  status_e            status_q;
  logic [31:0]        seg_seq_q;
  logic [15:0]        seg_total_len_q, seg_ident_q, payload_offset_q, payload_len_q;
  logic               last_segment_q;

  logic [15:0] head_w, maxp_w;
  logic        last;
  logic [15:0] seg_plen, whole_plen;
  logic [19:0] seg_cap;
  logic        too_many;

  assign head_w = 16'(head_q);
  assign maxp_w = 16'(maxp_q);

  // remaining payload fits in one segment
  assign last       = rem_q <= maxp_w;
  assign seg_plen   = last ? rem_q : maxp_w;
  assign whole_plen = (rcv_q >= head_w) ? rcv_q - head_w : 16'd0;
  assign seg_cap    = 20'(maxp_q) * 20'(MaxSegs);
  assign too_many   = 20'(rem_q) > seg_cap;

  assign stat_o = '{pass: pass_q, drop: bad_q | too_many, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
    end else if (cfg_we_i) begin
      mtu_q <= cfg_mtu_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      head_q  <= 7'(ip_header_len_i) + 7'(tcp_header_len_i);
      tot_q   <= total_len_i;
      rcv_q   <= received_len_i;
      seq_q   <= seq_number_i;
      ident_q <= ip_ident_i;
    end
    if (cmd_i.prep) begin
      maxp_q <= mtu_q - MtuW'(head_q);
      rem_q  <= tot_q - head_w;
      off_q  <= '0;
      idx_q  <= '0;
      pass_q <= rcv_q <= 16'(mtu_q);
      bad_q  <= (tot_q != rcv_q) || (MtuW'(head_q) >= mtu_q);
    end
    if (cmd_i.emit_seg) begin
      rem_q <= rem_q - maxp_w;
      off_q <= off_q + maxp_w;
      idx_q <= idx_q + SegIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_whole) begin
      status_q         <= StWhole;
      seg_seq_q        <= seq_q;
      seg_total_len_q  <= tot_q;
      seg_ident_q      <= ident_q;
      payload_offset_q <= head_w;
      payload_len_q    <= whole_plen;
      last_segment_q   <= 1'b1;
    end else if (cmd_i.emit_drop) begin
      status_q         <= StDrop;
      seg_seq_q        <= '0;
      seg_total_len_q  <= '0;
      seg_ident_q      <= '0;
      payload_offset_q <= '0;
      payload_len_q    <= '0;
      last_segment_q   <= 1'b1;
    end else if (cmd_i.emit_seg) begin
      status_q         <= StSeg;
      seg_seq_q        <= seq_q + 32'(off_q);
      seg_total_len_q  <= head_w + seg_plen;
      seg_ident_q      <= ident_q + 16'(idx_q);
      payload_offset_q <= head_w + off_q;
      payload_len_q    <= seg_plen;
      last_segment_q   <= last;
    end
  end

  assign status_o         = status_q;
  assign seg_seq_o        = seg_seq_q;
  assign seg_total_len_o  = seg_total_len_q;
  assign seg_ident_o      = seg_ident_q;
  assign payload_offset_o = payload_offset_q;
  assign payload_len_o    = payload_len_q;
  assign last_segment_o   = last_segment_q;

endmodule

FILE: hdl/tsg_ctrl.sv
module tsg_ctrl import tsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREP   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free, emit;
  cmd_t   cmd;

  // output register is empty or its result leaves this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.pass || stat_i.drop) begin
          if (slot_free) begin
            cmd.emit_whole = stat_i.pass;
            cmd.emit_drop  = !stat_i.pass;
            state_d        = S_IDLE;
          end
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_seg = 1'b1;
          if (stat_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign emit        = cmd.emit_whole || cmd.emit_drop || cmd.emit_seg;
  assign out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_emit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.emit_whole, cmd.emit_drop, cmd.emit_seg}))
    else $error("more than one result loaded at once");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("stalled result overwritten");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_PREP)
    else $error("accepted transfer not prepared");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_seg && stat_i.last) |=> state_q == S_IDLE)
    else $error("segmentation did not end after last segment");

endmodule

FILE: hdl/tcp_segmentation_header_gen.sv
// Channel   Handshake                 Payload
// --------  ------------------------  -------------------------------------------------
// input     in_valid_i / in_stall_o   ip/tcp header len, total/received len, seq, ident
// output    out_valid_o / out_stall_i status, seg seq/total len/ident, offset, len, last
// config    cfg_valid_i / cfg_ready_o cfg_mtu_i (always ready)
//
// An item is loaded, then prepared, then classified.
// A whole or dropped packet then gives one result.
// A segmented packet then gives one segment a cycle while the output is not stalled (up to 61 segments).
// Reset sets mtu to 1500, the controller to idle and clears the output valid.
// Output stall holds the result register and pauses segment generation.
module tcp_segmentation_header_gen import tsg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [MtuW-1:0] cfg_mtu_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [5:0]      ip_header_len_i,
  input  logic [5:0]      tcp_header_len_i,
  input  logic [15:0]     total_len_i,
  input  logic [15:0]     received_len_i,
  input  logic [31:0]     seq_number_i,
  input  logic [15:0]     ip_ident_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      status_o,
  output logic [31:0]     seg_seq_o,
  output logic [15:0]     seg_total_len_o,
  output logic [15:0]     seg_ident_o,
  output logic [15:0]     payload_offset_o,
  output logic [15:0]     payload_len_o,
  output logic            last_segment_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tsg_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_mtu_i        (cfg_mtu_i),
    .ip_header_len_i  (ip_header_len_i),
    .tcp_header_len_i (tcp_header_len_i),
    .total_len_i      (total_len_i),
    .received_len_i   (received_len_i),
    .seq_number_i     (seq_number_i),
    .ip_ident_i       (ip_ident_i),
    .status_o         (status_o),
    .seg_seq_o        (seg_seq_o),
    .seg_total_len_o  (seg_total_len_o),
    .seg_ident_o      (seg_ident_o),
    .payload_offset_o (payload_offset_o),
    .payload_len_o    (payload_len_o),
    .last_segment_o   (last_segment_o)
  );

endmodule
